@@ sv/crc32_msb_first_preload_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef CRC32_MSB_FIRST_PRELOAD_MACROS_SVH
`define CRC32_MSB_FIRST_PRELOAD_MACROS_SVH

// Checked at every clock edge outside reset.
`define CRC32MP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CRC32MP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/crc32mp_pkg.sv @@
package crc32mp_pkg;

  localparam logic [31:0] POLY_RESET   = 32'h04C1_1DB7;
  localparam logic [2:0]  LOADED_FULL  = 3'd4;

  typedef logic [2:0] count_t;

  typedef struct packed {
    logic [31:0] remainder;
    count_t      bytes_loaded;
  } crc_state_t;

endpackage

@@ sv/crc32_msb_first_preload.sv @@
// A checksum is registered onto out_tdata in the cycle after the last byte's transfer.
// Throughput: one byte per cycle unless the output stalls; each byte update is a
// combinational loop through the register, preload or eight polynomial shift steps.
// Reset (rst_n low at a clock edge): remainder and byte count cleared, polynomial
// set to 0x04C11DB7, output emptied.
module crc32_msb_first_preload (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] empty_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] checksum
);
  import crc32mp_pkg::*;

  crc_state_t  state_r, state_nxt, state_upd;
  logic [31:0] poly_r;
  logic [31:0] final_value;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;
  logic        in_xfer;

  crc32mp_update u_update (
    .state_cur     (state_r),
    .polynomial    (poly_r),
    .data_byte     (in_tdata),
    .empty_message (in_tuser),
    .state_upd     (state_upd),
    .final_value   (final_value)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_xfer) begin
      if (in_tlast) begin
        state_nxt     = '0;
        out_valid_nxt = 1'b1;
      end else begin
        state_nxt = state_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      poly_r      <= POLY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        poly_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_tlast) begin
      out_data_r <= final_value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/crc32mp_update.sv @@
module crc32mp_update (
  input  crc32mp_pkg::crc_state_t state_cur,
  input  logic [31:0]             polynomial,
  input  logic [7:0]              data_byte,
  input  logic                    empty_message,
  output crc32mp_pkg::crc_state_t state_upd,
  output logic [31:0]             final_value
);
  import crc32mp_pkg::*;

  function automatic logic [31:0] table_entry(input logic [7:0] top,
                                              input logic [31:0] poly);
    logic [31:0] acc;
    acc = {top, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (acc[31]) begin
        acc = {acc[30:0], 1'b0} ^ poly;
      end else begin
        acc = {acc[30:0], 1'b0};
      end
    end
    return acc;
  endfunction

  logic [31:0] packed_byte;
  logic [31:0] loaded;
  count_t      cnt_inc;

  always_comb begin
    unique case (state_cur.bytes_loaded[1:0])
      2'd0:    packed_byte = {data_byte, 24'h0};
      2'd1:    packed_byte = {8'h0, data_byte, 16'h0};
      2'd2:    packed_byte = {16'h0, data_byte, 8'h0};
      default: packed_byte = {24'h0, data_byte};
    endcase
  end

  assign loaded  = state_cur.remainder | packed_byte;
  assign cnt_inc = state_cur.bytes_loaded + count_t'(1);

  always_comb begin
    state_upd = state_cur;
    if (!empty_message) begin
      if (state_cur.bytes_loaded[2]) begin
        state_upd.bytes_loaded = LOADED_FULL;
        state_upd.remainder    = {state_cur.remainder[23:0], data_byte}
                               ^ table_entry(state_cur.remainder[31:24], polynomial);
      end else begin
        state_upd.bytes_loaded = cnt_inc;
        state_upd.remainder    = cnt_inc[2] ? ~loaded : loaded;
      end
    end
  end

  assign final_value = state_upd.bytes_loaded[2] ? ~state_upd.remainder
                                                 : state_upd.remainder;

endmodule

@@ sv/crc32mp_checker.sv @@
`include "crc32_msb_first_preload_macros.svh"

module crc32mp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic in_xfer;
  logic out_stall;
  logic out_free;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_free  = !out_tvalid || out_tready;

  // A stalled checksum must stay put until it is taken.
  `CRC32MP_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "checksum not held")

  // The final byte's transfer always yields a checksum in the next cycle.
  `CRC32MP_ASSERT(a_last_emits, in_xfer && in_tlast |=> out_tvalid, "no checksum after last")

  // Intermediate bytes never produce a result on a free output.
  `CRC32MP_ASSERT(a_mid_silent, in_xfer && !in_tlast && out_free |=> !out_tvalid, "stray checksum")

  // An empty output register never blocks the input.
  `CRC32MP_ASSERT(a_ready_free, !out_tvalid |-> in_tready, "input blocked with empty output")

  // Reset empties the output.
  `CRC32MP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind crc32_msb_first_preload crc32mp_checker u_crc32mp_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crc32mp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int PHASES = 8;
  localparam int LONG_STALL = 300;
  localparam int SETTLE = 8;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } msg_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  msg_byte_t   byte_queue[$];
  logic [31:0] checksums_due[$];

  logic [31:0] crc_poly;
  logic [31:0] crc_reg;
  count_t      crc_loaded;

  msg_byte_t   offered;
  logic [31:0] want_sum;
  int          tx_wait = 0;
  int          rx_wait = 0;
  int          tx_idle_max = 3;
  int          rx_idle_max = 3;
  int          stall_req = 0;
  int          stall_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  crc32_msb_first_preload i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] byte_residue(input logic [7:0] top, input logic [31:0] poly);
    logic [31:0] acc;
    acc = {top, 24'h0};
    for (int k = 0; k < 8; k++) begin
      acc = acc[31] ? ((acc << 1) ^ poly) : (acc << 1);
    end
    return acc;
  endfunction

  function automatic void crc_absorb(input msg_byte_t it);
    if (!it.empty) begin
      if (crc_loaded < LOADED_FULL) begin
        crc_reg[31 - 8 * crc_loaded -: 8] = it.data;
        crc_loaded = crc_loaded + 1'b1;
        if (crc_loaded == LOADED_FULL) begin
          crc_reg = ~crc_reg;
        end
      end else begin
        crc_reg = {crc_reg[23:0], it.data} ^ byte_residue(crc_reg[31:24], crc_poly);
      end
    end
    if (it.last) begin
      checksums_due.push_back((crc_loaded == LOADED_FULL) ? ~crc_reg : crc_reg);
      crc_reg = '0;
      crc_loaded = '0;
    end
  endfunction

  function automatic void flag_error(input string msg);
    if (mismatches < SHOWN_ERRORS) begin
      $display("%0t: %s", $realtime, msg);
    end
    mismatches++;
  endfunction

  task automatic put(input logic [7:0] data, input logic last, input logic empty);
    msg_byte_t it;
    it.data = data;
    it.last = last;
    it.empty = empty;
    byte_queue.push_back(it);
  endtask

  // Mostly well-formed messages of random length, with stray empty-flag
  // transfers mixed in and some messages closed by an empty last transfer.
  task automatic queue_random_message(inout int counted);
    int len;
    int pick;
    logic end_empty;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      len = 0;
    end else if (pick < 50) begin
      len = $urandom_range(1, 6);
    end else if (pick < 88) begin
      len = $urandom_range(7, 16);
    end else begin
      len = $urandom_range(17, 48);
    end
    end_empty = (len == 0) || ($urandom_range(0, 6) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        put(8'($urandom), 1'b0, 1'b1);
      end
      put(8'($urandom), !end_empty && (i == len - 1), 1'b0);
      counted++;
    end
    if (end_empty) begin
      if ($urandom_range(0, 7) == 0) begin
        put(8'($urandom), 1'b0, 1'b1);
      end
      put(8'($urandom), 1'b1, 1'b1);
      counted++;
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_tvalid || checksums_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_poly(input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    crc_poly = value;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        crc_absorb(offered);
      end
      if (!in_tvalid || in_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_tvalid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          offered = byte_queue.pop_front();
          in_tdata <= offered.data;
          in_tlast <= offered.last;
          in_tuser <= offered.empty;
          in_tvalid <= 1'b1;
          tx_wait = $urandom_range(0, tx_idle_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rx_wait = $urandom_range(0, rx_idle_max);
      end
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        rx_wait = LONG_STALL;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (checksums_due.size() == 0) begin
        flag_error($sformatf("unexpected checksum %h", out_tdata));
      end else begin
        want_sum = checksums_due.pop_front();
        if (out_tdata !== want_sum) begin
          flag_error($sformatf("checksum expected %h actual %h", want_sum, out_tdata));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    logic [31:0] phase_poly [PHASES];
    int counted;
    phase_poly[0] = POLY_RESET;
    phase_poly[1] = 32'h0000_0000;
    phase_poly[2] = 32'hFFFF_FFFF;
    phase_poly[3] = 32'h0000_0001;
    phase_poly[4] = 32'h8000_0000;
    phase_poly[5] = $urandom;
    phase_poly[6] = $urandom;
    phase_poly[7] = POLY_RESET;
    crc_poly = POLY_RESET;
    crc_reg = '0;
    crc_loaded = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty message, then short messages that come out as packed bytes.
    put(8'hA5, 1'b1, 1'b1);
    put(8'hFF, 1'b1, 1'b0);
    put(8'h80, 1'b0, 1'b0);
    put(8'h01, 1'b1, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(8'h80, 1'b0, 1'b0);
    put(8'h01, 1'b1, 1'b0);
    // First byte past a preload of all-ones bytes, which leaves an all-zeros register.
    put(8'hFF, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(8'h00, 1'b1, 1'b0);
    // Short message closed by an empty last transfer.
    put(8'h12, 1'b0, 1'b0);
    put(8'h34, 1'b0, 1'b0);
    put(8'h56, 1'b0, 1'b0);
    put(8'hFF, 1'b1, 1'b1);
    // An empty transfer inside a message changes nothing.
    put(8'hAB, 1'b0, 1'b0);
    put(8'h77, 1'b0, 1'b1);
    put(8'hCD, 1'b0, 1'b0);
    put(8'hEF, 1'b0, 1'b0);
    put(8'h01, 1'b0, 1'b0);
    put(8'h23, 1'b0, 1'b0);
    put(8'h45, 1'b1, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      repeat (SETTLE) @(posedge clk);
      write_poly(phase_poly[phase]);
      tx_idle_max = (phase % 4 < 2) ? 8 : 0;
      rx_idle_max = (phase % 2 == 1) ? 8 : 0;
      if (phase == 2) begin
        tx_idle_max = 0;
      end
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        queue_random_message(counted);
      end
      if (phase == 2) begin
        stall_req++;
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && checksums_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
